[rtl/mecanum_wheel_speed_mixer_defines.svh]
`ifndef MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define MWSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MWSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mwsm_pkg.sv]
package mwsm_pkg;

   localparam int VEL_W    = 16;
   localparam int SPEED_W  = 21;
   localparam int CYCLE_W  = 16;
   localparam int LIMIT_W  = 20;
   localparam int SPAN_W   = 12;
   localparam int RADIUS_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   localparam int MAG_W  = 28;
   localparam int PROD_W = 48;
   localparam int CNT_W  = 6;

   localparam logic [CYCLE_W-1:0]  CYCLE_RST  = 16'd1;
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 20'd20000;
   localparam logic [SPAN_W-1:0]   SPAN_RST   = 12'd150;
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd30;

   localparam logic [MAG_W-1:0]   SPAN_SCALE  = 28'd1000;
   localparam logic [LIMIT_W-1:0] SPEED_SCALE = 20'd1000;

   localparam logic [CNT_W-1:0] SHORT_STEPS = 6'd28;
   localparam logic [CNT_W-1:0] LONG_STEPS  = 6'd48;

   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd3;

   localparam logic [1:0] MODE_DISABLE = 2'd0;
   localparam logic [1:0] MODE_SUSPEND = 2'd1;
   localparam logic [1:0] MODE_BRAKE   = 2'd2;
   localparam logic [1:0] MODE_RUN     = 2'd3;

   localparam logic [1:0] ACT_COAST = 2'd0;
   localparam logic [1:0] ACT_BRAKE = 2'd1;
   localparam logic [1:0] ACT_RUN   = 2'd2;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_DIV   = 9'b000000100,
      ST_FIN   = 9'b000001000,
      ST_MIX   = 9'b000010000,
      ST_PEAK  = 9'b000100000,
      ST_CHECK = 9'b001000000,
      ST_SCALE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      OP_ROT = 2'd0,
      OP_WHL = 2'd1,
      OP_SCL = 2'd2
   } op_type;

endpackage

[rtl/mecanum_wheel_speed_mixer.sv]
// One restoring divider (1 quotient bit/cycle) serves all multiply-divide steps:
// a firing run tick scales the yaw term, then each wheel, and the wheels again
// when they exceed the limit; a firing stop tick goes straight to the done state,
// a non-firing tick only advances the tick counter. One item at a time: req_stall
// is high until the result is in the output register. Reset (synchronous, active
// high) restores register defaults, clears the tick counter and drops rsp_valid.
module mecanum_wheel_speed_mixer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_chassis_mode,
   input  logic signed [mwsm_pkg::VEL_W-1:0]      req_velocity_x,
   input  logic signed [mwsm_pkg::VEL_W-1:0]      req_velocity_y,
   input  logic signed [mwsm_pkg::VEL_W-1:0]      req_yaw_rate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_drive_action,
   output logic signed [mwsm_pkg::SPEED_W-1:0]    rsp_wheel0_speed,
   output logic signed [mwsm_pkg::SPEED_W-1:0]    rsp_wheel1_speed,
   output logic signed [mwsm_pkg::SPEED_W-1:0]    rsp_wheel2_speed,
   output logic signed [mwsm_pkg::SPEED_W-1:0]    rsp_wheel3_speed,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mwsm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mwsm_pkg::CSR_DAT_W-1:0]         csr_data
);

   logic [mwsm_pkg::CYCLE_W-1:0]  cycle_ff, cycle_in;
   logic [mwsm_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   logic [mwsm_pkg::SPAN_W-1:0]   span_ff, span_in;
   logic [mwsm_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [mwsm_pkg::CYCLE_W-1:0]  tick_ff, tick_in;
   mwsm_pkg::state_type           state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   mwsm_pkg::op_type              op_ff, op_in;
   logic [1:0]                    idx_ff, idx_in;
   logic signed [15:0]            vx_ff, vx_in, vy_ff, vy_in;
   logic signed [18:0]            rot_ff, rot_in;
   logic signed [28:0]            w_ff [4];
   logic signed [28:0]            w_in [4];
   logic [mwsm_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [mwsm_pkg::MAG_W-1:0]    rem_ff, rem_in;
   logic [mwsm_pkg::PROD_W-1:0]   quo_ff, quo_in;
   logic [mwsm_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mwsm_pkg::MAG_W-1:0]    peak_ff, peak_in;
   logic [1:0]                    act_ff, act_in;
   logic [1:0]                    rsp_act_ff, rsp_act_in;
   logic [mwsm_pkg::SPEED_W-1:0]  rsp_spd_ff [4];
   logic [mwsm_pkg::SPEED_W-1:0]  rsp_spd_in [4];

   logic                          accept;
   logic                          csr_write;
   logic [mwsm_pkg::CYCLE_W-1:0]  cycle_eff;
   logic                          fire;
   logic [mwsm_pkg::LIMIT_W-1:0]  mul_b;
   logic [mwsm_pkg::PROD_W-1:0]   prod;
   logic [mwsm_pkg::MAG_W-1:0]    divisor;
   logic [mwsm_pkg::MAG_W:0]      trial;
   logic [mwsm_pkg::MAG_W:0]      diff;
   logic                          take;
   logic signed [28:0]            qmag;
   logic signed [28:0]            res;
   logic signed [19:0]            vx_e, vy_e, rot_e, mix;
   logic [19:0]                   mix_mag;
   logic signed [28:0]            w_cur;
   logic [28:0]                   w_abs;
   logic [16:0]                   om_abs;
   logic                          out_free;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (state_ff != mwsm_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cycle_eff = (cycle_ff == '0) ? mwsm_pkg::CYCLE_W'(1) : cycle_ff;
   assign fire      = (tick_ff >= cycle_eff - mwsm_pkg::CYCLE_W'(1));

   assign om_abs = req_yaw_rate[15] ? (17'd0 - {req_yaw_rate[15], req_yaw_rate})
                                    : {1'b0, req_yaw_rate};

   always_comb begin
      unique case (op_ff)
         mwsm_pkg::OP_ROT: begin
            mul_b   = {8'd0, span_ff};
            divisor = mwsm_pkg::SPAN_SCALE;
         end
         mwsm_pkg::OP_WHL: begin
            mul_b   = mwsm_pkg::SPEED_SCALE;
            divisor = (radius_ff == '0) ? 28'd1 : {18'd0, radius_ff};
         end
         default: begin
            mul_b   = limit_ff;
            divisor = peak_ff;
         end
      endcase
   end

   assign prod  = {20'd0, mag_ff} * {28'd0, mul_b};
   assign trial = {rem_ff, quo_ff[mwsm_pkg::PROD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = (trial >= {1'b0, divisor});
   assign qmag  = {1'b0, quo_ff[27:0]};
   assign res   = neg_ff ? (29'sd0 - qmag) : qmag;

   assign vx_e  = {{4{vx_ff[15]}}, vx_ff};
   assign vy_e  = {{4{vy_ff[15]}}, vy_ff};
   assign rot_e = {rot_ff[18], rot_ff};

   always_comb begin
      unique case (idx_ff)
         2'd0:    mix = vx_e - vy_e - rot_e;
         2'd1:    mix = -vx_e - vy_e - rot_e;
         2'd2:    mix = vx_e + vy_e - rot_e;
         default: mix = -vx_e + vy_e - rot_e;
      endcase
   end

   assign mix_mag = mix[19] ? (20'd0 - mix) : mix;
   assign w_cur   = w_ff[idx_ff];
   assign w_abs   = w_cur[28] ? (29'd0 - w_cur) : w_cur;

   always_comb begin
      cycle_in     = cycle_ff;
      limit_in     = limit_ff;
      span_in      = span_ff;
      radius_in    = radius_ff;
      tick_in      = tick_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      rot_in       = rot_ff;
      w_in         = w_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      peak_in      = peak_ff;
      act_in       = act_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_spd_in   = rsp_spd_ff;

      if (csr_write) begin
         unique case (csr_index)
            mwsm_pkg::CSR_CYCLE:  cycle_in  = csr_data[mwsm_pkg::CYCLE_W-1:0];
            mwsm_pkg::CSR_LIMIT:  limit_in  = csr_data[mwsm_pkg::LIMIT_W-1:0];
            mwsm_pkg::CSR_SPAN:   span_in   = csr_data[mwsm_pkg::SPAN_W-1:0];
            mwsm_pkg::CSR_RADIUS: radius_in = csr_data[mwsm_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mwsm_pkg::ST_IDLE: begin
            if (accept) begin
               if (!fire) begin
                  tick_in = tick_ff + mwsm_pkg::CYCLE_W'(1);
               end else begin
                  tick_in = '0;
                  if (req_chassis_mode == mwsm_pkg::MODE_RUN) begin
                     vx_in    = req_velocity_x;
                     vy_in    = req_velocity_y;
                     mag_in   = {11'd0, om_abs};
                     neg_in   = req_yaw_rate[15];
                     op_in    = mwsm_pkg::OP_ROT;
                     act_in   = mwsm_pkg::ACT_RUN;
                     state_in = mwsm_pkg::ST_MUL;
                  end else begin
                     act_in   = (req_chassis_mode == mwsm_pkg::MODE_BRAKE) ?
                                mwsm_pkg::ACT_BRAKE : mwsm_pkg::ACT_COAST;
                     for (int i = 0; i < 4; i++) begin
                        w_in[i] = '0;
                     end
                     state_in = mwsm_pkg::ST_DONE;
                  end
               end
            end
         end
         mwsm_pkg::ST_MUL: begin
            rem_in = '0;
            if (op_ff == mwsm_pkg::OP_SCL) begin
               quo_in = prod;
               cnt_in = mwsm_pkg::LONG_STEPS;
            end else begin
               quo_in = {prod[27:0], 20'd0};
               cnt_in = mwsm_pkg::SHORT_STEPS;
            end
            state_in = mwsm_pkg::ST_DIV;
         end
         mwsm_pkg::ST_DIV: begin
            rem_in = take ? diff[27:0] : trial[27:0];
            quo_in = {quo_ff[mwsm_pkg::PROD_W-2:0], take};
            cnt_in = cnt_ff - mwsm_pkg::CNT_W'(1);
            if (cnt_ff == mwsm_pkg::CNT_W'(1)) begin
               state_in = mwsm_pkg::ST_FIN;
            end
         end
         mwsm_pkg::ST_FIN: begin
            unique case (op_ff)
               mwsm_pkg::OP_ROT: begin
                  rot_in   = res[18:0];
                  idx_in   = 2'd0;
                  state_in = mwsm_pkg::ST_MIX;
               end
               mwsm_pkg::OP_WHL: begin
                  w_in[idx_ff] = res;
                  idx_in       = idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     peak_in  = '0;
                     state_in = mwsm_pkg::ST_PEAK;
                  end else begin
                     state_in = mwsm_pkg::ST_MIX;
                  end
               end
               default: begin
                  w_in[idx_ff] = res;
                  idx_in       = idx_ff + 2'd1;
                  state_in     = (idx_ff == 2'd3) ? mwsm_pkg::ST_DONE : mwsm_pkg::ST_SCALE;
               end
            endcase
         end
         mwsm_pkg::ST_MIX: begin
            mag_in   = {8'd0, mix_mag};
            neg_in   = mix[19];
            op_in    = mwsm_pkg::OP_WHL;
            state_in = mwsm_pkg::ST_MUL;
         end
         mwsm_pkg::ST_PEAK: begin
            if (w_abs[27:0] > peak_ff) begin
               peak_in = w_abs[27:0];
            end
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = mwsm_pkg::ST_CHECK;
            end
         end
         mwsm_pkg::ST_CHECK: begin
            idx_in   = 2'd0;
            state_in = (peak_ff > {8'd0, limit_ff}) ? mwsm_pkg::ST_SCALE : mwsm_pkg::ST_DONE;
         end
         mwsm_pkg::ST_SCALE: begin
            mag_in   = w_abs[27:0];
            neg_in   = w_cur[28];
            op_in    = mwsm_pkg::OP_SCL;
            state_in = mwsm_pkg::ST_MUL;
         end
         mwsm_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = act_ff;
               for (int i = 0; i < 4; i++) begin
                  rsp_spd_in[i] = w_ff[i][mwsm_pkg::SPEED_W-1:0];
               end
               state_in = mwsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mwsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff     <= mwsm_pkg::CYCLE_RST;
         limit_ff     <= mwsm_pkg::LIMIT_RST;
         span_ff      <= mwsm_pkg::SPAN_RST;
         radius_ff    <= mwsm_pkg::RADIUS_RST;
         tick_ff      <= '0;
         state_ff     <= mwsm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cycle_ff     <= cycle_in;
         limit_ff     <= limit_in;
         span_ff      <= span_in;
         radius_ff    <= radius_in;
         tick_ff      <= tick_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      rot_ff     <= rot_in;
      w_ff       <= w_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      peak_ff    <= peak_in;
      act_ff     <= act_in;
      rsp_act_ff <= rsp_act_in;
      rsp_spd_ff <= rsp_spd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_action = rsp_act_ff;
   assign rsp_wheel0_speed = rsp_spd_ff[0];
   assign rsp_wheel1_speed = rsp_spd_ff[1];
   assign rsp_wheel2_speed = rsp_spd_ff[2];
   assign rsp_wheel3_speed = rsp_spd_ff[3];

endmodule

[rtl/mwsm_checker.sv]
`include "mecanum_wheel_speed_mixer_defines.svh"

module mwsm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_chassis_mode,
   input logic signed [mwsm_pkg::VEL_W-1:0]   req_velocity_x,
   input logic signed [mwsm_pkg::VEL_W-1:0]   req_velocity_y,
   input logic signed [mwsm_pkg::VEL_W-1:0]   req_yaw_rate,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [1:0]                          rsp_drive_action,
   input logic signed [mwsm_pkg::SPEED_W-1:0] rsp_wheel0_speed,
   input logic signed [mwsm_pkg::SPEED_W-1:0] rsp_wheel1_speed,
   input logic signed [mwsm_pkg::SPEED_W-1:0] rsp_wheel2_speed,
   input logic signed [mwsm_pkg::SPEED_W-1:0] rsp_wheel3_speed,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [mwsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [mwsm_pkg::CSR_DAT_W-1:0]      csr_data
);

   `MWSM_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `MWSM_ASSERT(a_action_legal, clock, reset, rsp_valid |-> (rsp_drive_action == mwsm_pkg::ACT_COAST || rsp_drive_action == mwsm_pkg::ACT_BRAKE || rsp_drive_action == mwsm_pkg::ACT_RUN), "illegal drive action")

   `MWSM_ASSERT(a_stop_zero, clock, reset, (rsp_valid && rsp_drive_action != mwsm_pkg::ACT_RUN) |-> (rsp_wheel0_speed == '0 && rsp_wheel1_speed == '0 && rsp_wheel2_speed == '0 && rsp_wheel3_speed == '0), "stop item with nonzero speed")

   `MWSM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive_action) && $stable(rsp_wheel0_speed) && $stable(rsp_wheel1_speed) && $stable(rsp_wheel2_speed) && $stable(rsp_wheel3_speed)), "stalled item changed")

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (.*);

[dv/mecanum_wheel_speed_mixer_checker.sv]
`timescale 1ns / 100ps

module mecanum_wheel_speed_mixer_checker
   import mwsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_chassis_mode,
   input  logic signed [VEL_W-1:0]    req_velocity_x,
   input  logic signed [VEL_W-1:0]    req_velocity_y,
   input  logic signed [VEL_W-1:0]    req_yaw_rate,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_drive_action,
   input  logic signed [SPEED_W-1:0]  rsp_wheel0_speed,
   input  logic signed [SPEED_W-1:0]  rsp_wheel1_speed,
   input  logic signed [SPEED_W-1:0]  rsp_wheel2_speed,
   input  logic signed [SPEED_W-1:0]  rsp_wheel3_speed,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data,
   output int                         fail_count,
   output int                         cmds_due,
   output int                         cmds_checked
);

   typedef struct packed {
      logic [1:0]               action;
      logic [3:0][SPEED_W-1:0]  speed;
   } wheel_cmd_t;

   wheel_cmd_t               wheel_cmds_due [$];
   wheel_cmd_t               due;
   logic [3:0][SPEED_W-1:0]  seen_speed;
   logic [CYCLE_W-1:0]       cycle_cfg;
   logic [CYCLE_W-1:0]       last_tick;
   logic [CYCLE_W-1:0]       tick_count;
   logic [LIMIT_W-1:0]       limit_cfg;
   logic [SPAN_W-1:0]        span_cfg;
   logic [RADIUS_W-1:0]      radius_cfg;
   int                       mismatches = 0;
   int                       checked_count = 0;

   assign fail_count   = mismatches;
   assign cmds_checked = checked_count;
   assign seen_speed   = {rsp_wheel3_speed, rsp_wheel2_speed, rsp_wheel1_speed, rsp_wheel0_speed};

   function automatic wheel_cmd_t mix_wheel_command(input logic [1:0] mode,
                                                    input logic signed [VEL_W-1:0] vx,
                                                    input logic signed [VEL_W-1:0] vy,
                                                    input logic signed [VEL_W-1:0] yaw);
      wheel_cmd_t cmd;
      longint     sum [4];
      longint     rot;
      longint     radius;
      longint     limit;
      longint     peak;
      longint     mag;
      cmd = '0;
      cmd.action = ACT_COAST;
      if (mode == MODE_BRAKE) begin
         cmd.action = ACT_BRAKE;
      end else if (mode == MODE_RUN) begin
         cmd.action = ACT_RUN;
         radius = (radius_cfg == '0) ? 64'sd1 : longint'(radius_cfg);
         limit  = longint'(limit_cfg);
         rot    = longint'(yaw) * longint'(span_cfg) / longint'(SPAN_SCALE);
         sum[0] = longint'(vx) - longint'(vy) - rot;
         sum[1] = -longint'(vx) - longint'(vy) - rot;
         sum[2] = longint'(vx) + longint'(vy) - rot;
         sum[3] = -longint'(vx) + longint'(vy) - rot;
         peak = 0;
         for (int i = 0; i < 4; i++) begin
            sum[i] = sum[i] * longint'(SPEED_SCALE) / radius;
            mag = (sum[i] < 0) ? -sum[i] : sum[i];
            if (mag > peak)
               peak = mag;
         end
         // scale all four so the peak lands on the limit
         if (peak > limit) begin
            for (int i = 0; i < 4; i++)
               sum[i] = sum[i] * limit / peak;
         end
         for (int i = 0; i < 4; i++)
            cmd.speed[i] = SPEED_W'(sum[i]);
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 50)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cycle_cfg  <= CYCLE_RST;
         limit_cfg  <= LIMIT_RST;
         span_cfg   <= SPAN_RST;
         radius_cfg <= RADIUS_RST;
         tick_count <= '0;
         wheel_cmds_due.delete();
         cmds_due   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wheel_cmds_due.size() == 0) begin
               report_mismatch("result item arrived with no command due");
            end else begin
               due = wheel_cmds_due.pop_front();
               checked_count++;
               if (rsp_drive_action !== due.action)
                  report_mismatch($sformatf("drive_action %0d, expected %0d",
                                            rsp_drive_action, due.action));
               for (int i = 0; i < 4; i++) begin
                  if (seen_speed[i] !== due.speed[i])
                     report_mismatch($sformatf("wheel%0d_speed %0d, expected %0d", i,
                                               $signed(seen_speed[i]), $signed(due.speed[i])));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CYCLE:  cycle_cfg  <= csr_data[CYCLE_W-1:0];
               CSR_LIMIT:  limit_cfg  <= csr_data[LIMIT_W-1:0];
               CSR_SPAN:   span_cfg   <= csr_data[SPAN_W-1:0];
               CSR_RADIUS: radius_cfg <= csr_data[RADIUS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            last_tick = (cycle_cfg == '0) ? '0 : cycle_cfg - 1'b1;
            if (tick_count < last_tick) begin
               tick_count <= tick_count + 1'b1;
            end else begin
               tick_count <= '0;
               wheel_cmds_due.push_back(mix_wheel_command(req_chassis_mode, req_velocity_x,
                                                          req_velocity_y, req_yaw_rate));
            end
         end
         cmds_due <= wheel_cmds_due.size();
      end
   end

endmodule

[dv/tb_mecanum_wheel_speed_mixer.sv]
`timescale 1ns / 100ps

module tb_mecanum_wheel_speed_mixer;
   import mwsm_pkg::*;

   localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_chassis_mode;
   logic signed [VEL_W-1:0]    req_velocity_x;
   logic signed [VEL_W-1:0]    req_velocity_y;
   logic signed [VEL_W-1:0]    req_yaw_rate;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [1:0]                 rsp_drive_action;
   logic signed [SPEED_W-1:0]  rsp_wheel0_speed;
   logic signed [SPEED_W-1:0]  rsp_wheel1_speed;
   logic signed [SPEED_W-1:0]  rsp_wheel2_speed;
   logic signed [SPEED_W-1:0]  rsp_wheel3_speed;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DAT_W-1:0]       csr_data;
   int                         fail_count;
   int                         cmds_due;
   int                         cmds_checked;

   logic                       eager;
   int                         hold_trigger;
   int                         hold_seen = 0;
   int                         hold_left = 0;
   int                         ticks_sent = 0;
   int                         settings_used = 1;

   mecanum_wheel_speed_mixer DUT (.*);

   mecanum_wheel_speed_mixer_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("Timeout with %0d commands still due", cmds_due);
      $display("CHECKS FAILED");
      $finish;
   end

   // output side: random stall, eager stretches, and one long hold-off per trigger
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = 2000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (eager) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 33);
         end
      end
   end

   function automatic logic signed [VEL_W-1:0] random_velocity();
      case ($urandom_range(5))
         0: return VEL_MAX;
         1: return VEL_MIN;
         2: return VEL_W'(int'($urandom_range(400)) - 200);
         default: return VEL_W'($urandom);
      endcase
   endfunction

   task automatic send_tick(input logic [1:0] mode, input logic signed [VEL_W-1:0] vx,
                            input logic signed [VEL_W-1:0] vy,
                            input logic signed [VEL_W-1:0] yaw);
      if (!eager) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_chassis_mode <= mode;
      req_velocity_x   <= vx;
      req_velocity_y   <= vy;
      req_yaw_rate     <= yaw;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   task automatic random_tick();
      logic [1:0] mode;
      mode = ($urandom_range(9) < 6) ? MODE_RUN : 2'($urandom);
      send_tick(mode, random_velocity(), random_velocity(), random_velocity());
   endtask

   task automatic wait_drained(input int quiet);
      req_valid <= 1'b0;
      do @(posedge clock); while (cmds_due != 0);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // unused upper data bits carry noise; an unmapped index is written first
   task automatic configure(input logic [CYCLE_W-1:0] cyc, input logic [LIMIT_W-1:0] lim,
                            input logic [SPAN_W-1:0] spn, input logic [RADIUS_W-1:0] rad);
      logic [CSR_DAT_W-1:0] data;
      wait_drained(16);
      write_reg(CSR_RADIUS + 3'($urandom_range(1, 4)), CSR_DAT_W'($urandom));
      data = CSR_DAT_W'($urandom);
      data[CYCLE_W-1:0] = cyc;
      write_reg(CSR_CYCLE, data);
      write_reg(CSR_LIMIT, lim);
      data = CSR_DAT_W'($urandom);
      data[SPAN_W-1:0] = spn;
      write_reg(CSR_SPAN, data);
      data = CSR_DAT_W'($urandom);
      data[RADIUS_W-1:0] = rad;
      write_reg(CSR_RADIUS, data);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_chassis_mode <= MODE_DISABLE;
      req_velocity_x   <= '0;
      req_velocity_y   <= '0;
      req_yaw_rate     <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_CYCLE;
      csr_data         <= '0;
      eager            <= 1'b0;
      hold_trigger     <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, register defaults
      send_tick(MODE_DISABLE, VEL_MAX, VEL_MIN, 16'sd1234);
      send_tick(MODE_SUSPEND, -16'sd1, 16'sd1, -16'sd1);
      send_tick(MODE_BRAKE, 16'sd500, 16'sd500, 16'sd500);
      send_tick(MODE_RUN, 16'sd0, 16'sd0, 16'sd0);
      send_tick(MODE_RUN, 16'sd100, 16'sd0, 16'sd0);
      send_tick(MODE_RUN, 16'sd0, 16'sd0, 16'sd1000);
      send_tick(MODE_RUN, VEL_MAX, VEL_MAX, VEL_MAX);
      send_tick(MODE_RUN, VEL_MIN, VEL_MIN, VEL_MIN);
      send_tick(MODE_RUN, VEL_MAX, VEL_MIN, VEL_MIN);

      // zero cycle and zero radius act as one, limit beyond nominal range
      configure('0, '1, '1, '0);
      send_tick(MODE_RUN, VEL_MIN, VEL_MAX, VEL_MAX);
      send_tick(MODE_RUN, VEL_MAX, VEL_MAX, VEL_MIN);
      send_tick(MODE_RUN, 16'sd1, -16'sd1, 16'sd0);
      send_tick(MODE_RUN, 16'sd0, 16'sd0, -16'sd1);

      // longest cycle, then lowered below the tick count
      configure('1, '0, '0, '1);
      send_tick(MODE_RUN, VEL_MAX, 16'sd3, 16'sd9);
      send_tick(MODE_BRAKE, VEL_MIN, 16'sd0, 16'sd0);
      send_tick(MODE_RUN, 16'sd7, VEL_MAX, VEL_MIN);
      wait_drained(16);
      write_reg(CSR_CYCLE, CSR_DAT_W'(2));
      csr_valid <= 1'b0;
      send_tick(MODE_RUN, VEL_MAX, 16'sd0, 16'sd0);
      send_tick(MODE_RUN, 16'sd100, 16'sd0, 16'sd0);
      send_tick(MODE_RUN, -16'sd100, 16'sd5, 16'sd7);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(CYCLE_RST, LIMIT_RST, SPAN_RST, RADIUS_RST);
            1: configure(CYCLE_W'(2), '1, '1, RADIUS_W'(1));
            2: configure(CYCLE_W'(1), '0, '0, '1);
            3: configure(CYCLE_W'(3), LIMIT_W'(1000000), SPAN_W'(2000), '0);
            4: configure(CYCLE_W'(1), LIMIT_W'($urandom), SPAN_W'($urandom),
                         RADIUS_W'($urandom));
            default: configure(CYCLE_W'($urandom_range(1, 4)), LIMIT_W'($urandom),
                               SPAN_W'($urandom), RADIUS_W'($urandom));
         endcase
         for (int n = 0; n < 135; n++) begin
            if (phase == 0 && n == 0)
               eager <= 1'b1;
            if (phase == 0 && n == 40)
               eager <= 1'b0;
            if (phase == 1 && n == 20) begin
               eager <= 1'b1;
               hold_trigger <= hold_trigger + 1;
            end
            if (phase == 1 && n == 60)
               eager <= 1'b0;
            if (phase == 3 && n == 70)
               wait_drained(0);
            random_tick();
         end
      end

      wait_drained(400);
      $display("%0d heartbeat ticks sent under %0d register settings, %0d wheel commands checked",
               ticks_sent, settings_used, cmds_checked);
      $display("coast, brake and run modes, limit scaling, tick division and output hold-off");
      if (fail_count == 0 && cmds_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/mwsm_pkg.sv
rtl/mecanum_wheel_speed_mixer.sv
rtl/mwsm_checker.sv
dv/mecanum_wheel_speed_mixer_checker.sv
dv/tb_mecanum_wheel_speed_mixer.sv
